@@ rtl/stereo_ring_buffer_mixer_assert.svh @@
// assertion macros for the stereo ring buffer mixer
`ifndef STEREO_RING_BUFFER_MIXER_ASSERT_SVH
`define STEREO_RING_BUFFER_MIXER_ASSERT_SVH

// same-cycle implication on clk_i, off during reset
`define SRBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off during reset
`define SRBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/srbm_pkg.sv @@
// types, constants and helper functions shared by the stereo ring buffer mixer
package srbm_pkg;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_MIX     = 1'b1;

  localparam logic [15:0] GAIN_UNITY      = 16'h8000;
  localparam logic [15:0] MASTER_GAIN_RST = 16'h8000;
  localparam logic [15:0] SRC_GAIN_RST    = 16'h4000;
  localparam logic [1:0]  MUTE_RST        = 2'b00;

  localparam int REG_SLOTS = 2;

  typedef enum logic [2:0] {
    REG_MASTER_L = 3'd0,
    REG_MASTER_R = 3'd1,
    REG_SRC0_L   = 3'd2,
    REG_SRC0_R   = 3'd3,
    REG_SRC1_L   = 3'd4,
    REG_SRC1_R   = 3'd5,
    REG_MUTE     = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic               command;
    logic               source_sel;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mixed_left;
    logic signed [15:0] mixed_right;
  } out_item_t;

  // ring entry layout: right sample in the upper half
  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } frame_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } gain_pair_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic mul;
  } lane_ctrl_t;

  // master times source gain, limited to unity
  function automatic logic [15:0] lane_gain(logic [15:0] master, logic [15:0] src);
    logic [31:0] prod;
    prod = 32'(master) * 32'(src);
    if (prod[31:15] > 17'(GAIN_UNITY)) begin
      return GAIN_UNITY;
    end
    return prod[30:15];
  endfunction

endpackage

@@ rtl/stereo_ring_buffer_mixer.sv @@
// top level of the stereo ring buffer mixer: config registers, sequencer, lanes, merge
//
// A capture transaction writes the frame into the selected source's ring, and the
// block is ready again in the next cycle. A mix transaction reads the ring in every
// lane at acceptance, applies the per-lane gain multiply in ST_MUL, then the merge
// adds and saturates into the output register in ST_SUM, which waits while the output
// register stays stalled with an earlier result. Every source lane has its
// own ring memory, so all sources are read in the same cycle. The rings are not
// cleared after reset and no clearing pass runs: the reader only ever reaches frames
// that have been written. Registers are written through the APB port and should only
// change while no mix transaction is in flight.
module stereo_ring_buffer_mixer #(
  parameter int FRAME_DEPTH = 16384,
  parameter int SOURCES     = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srbm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srbm_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  `include "stereo_ring_buffer_mixer_assert.svh"

  srbm_pkg::state_e     state_q, state_d;
  srbm_pkg::gain_pair_t master_q;
  srbm_pkg::gain_pair_t src_gain_q [srbm_pkg::REG_SLOTS];
  logic [1:0]           mute_q;
  srbm_pkg::reg_idx_e   reg_idx;
  logic                 cfg_wr;
  logic                 in_accept;
  logic                 mix_start;
  logic                 merge_load;
  logic                 merge_free;
  logic                 mul_en;
  srbm_pkg::frame_t                 wr_frame;
  srbm_pkg::frame_t [SOURCES-1:0]   lane_scaled;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = srbm_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q.left        <= srbm_pkg::MASTER_GAIN_RST;
      master_q.right       <= srbm_pkg::MASTER_GAIN_RST;
      src_gain_q[0].left   <= srbm_pkg::SRC_GAIN_RST;
      src_gain_q[0].right  <= srbm_pkg::SRC_GAIN_RST;
      src_gain_q[1].left   <= srbm_pkg::SRC_GAIN_RST;
      src_gain_q[1].right  <= srbm_pkg::SRC_GAIN_RST;
      mute_q               <= srbm_pkg::MUTE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        srbm_pkg::REG_MASTER_L: master_q.left       <= pwdata[15:0];
        srbm_pkg::REG_MASTER_R: master_q.right      <= pwdata[15:0];
        srbm_pkg::REG_SRC0_L:   src_gain_q[0].left  <= pwdata[15:0];
        srbm_pkg::REG_SRC0_R:   src_gain_q[0].right <= pwdata[15:0];
        srbm_pkg::REG_SRC1_L:   src_gain_q[1].left  <= pwdata[15:0];
        srbm_pkg::REG_SRC1_R:   src_gain_q[1].right <= pwdata[15:0];
        srbm_pkg::REG_MUTE:     mute_q              <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      srbm_pkg::REG_MASTER_L: prdata = 32'(master_q.left);
      srbm_pkg::REG_MASTER_R: prdata = 32'(master_q.right);
      srbm_pkg::REG_SRC0_L:   prdata = 32'(src_gain_q[0].left);
      srbm_pkg::REG_SRC0_R:   prdata = 32'(src_gain_q[0].right);
      srbm_pkg::REG_SRC1_L:   prdata = 32'(src_gain_q[1].left);
      srbm_pkg::REG_SRC1_R:   prdata = 32'(src_gain_q[1].right);
      srbm_pkg::REG_MUTE:     prdata = 32'(mute_q);
      default:                prdata = '0;
    endcase
  end

  // sequencer
  assign in_stall_o = (state_q != srbm_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign mix_start  = in_accept && (in_data_i.command == srbm_pkg::CMD_MIX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srbm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mul_en     = 1'b0;
    merge_load = 1'b0;
    unique case (state_q)
      srbm_pkg::ST_IDLE: begin
        if (mix_start) begin
          state_d = srbm_pkg::ST_MUL;
        end
      end
      srbm_pkg::ST_MUL: begin
        mul_en  = 1'b1;
        state_d = srbm_pkg::ST_SUM;
      end
      srbm_pkg::ST_SUM: begin
        if (merge_free) begin
          merge_load = 1'b1;
          state_d    = srbm_pkg::ST_IDLE;
        end
      end
      default: state_d = srbm_pkg::ST_IDLE;
    endcase
  end

  assign wr_frame.left  = in_data_i.sample_left;
  assign wr_frame.right = in_data_i.sample_right;

  for (genvar s = 0; s < SOURCES; s++) begin : g_lane
    srbm_pkg::lane_ctrl_t ctrl;

    assign ctrl.wr  = in_accept && (in_data_i.command == srbm_pkg::CMD_CAPTURE)
                      && (int'(in_data_i.source_sel) == s);
    assign ctrl.rd  = mix_start;
    assign ctrl.mul = mul_en;

    srbm_lane #(
      .FRAME_DEPTH (FRAME_DEPTH)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .mute_i     (mute_q[s]),
      .master_i   (master_q),
      .src_gain_i (src_gain_q[s]),
      .wr_frame_i (wr_frame),
      .scaled_o   (lane_scaled[s])
    );
  end

  srbm_merge #(
    .SOURCES (SOURCES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (merge_load),
    .lanes_i     (lane_scaled),
    .free_o      (merge_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `SRBM_ASSERT_NOW(a_mix_reaches_sum, mix_start, ##2 (state_q == srbm_pkg::ST_SUM),
                   "mix transaction did not reach the merge step")
  `SRBM_ASSERT_NEXT(a_load_gives_result, merge_load, out_valid_o,
                    "merge load did not present a result")
  `SRBM_ASSERT_NOW(a_result_from_merge, $rose(out_valid_o),
                   $past(state_q == srbm_pkg::ST_SUM),
                   "result appeared without a merge step")

endmodule

@@ rtl/srbm_ram.sv @@
// generic single write port ram with registered read
module srbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/srbm_lane.sv @@
// one source lane: ring store, write and read counters, gain and scaling
module srbm_lane #(
  parameter int FRAME_DEPTH = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srbm_pkg::lane_ctrl_t ctrl_i,
  input  logic                mute_i,
  input  srbm_pkg::gain_pair_t master_i,
  input  srbm_pkg::gain_pair_t src_gain_i,
  input  srbm_pkg::frame_t     wr_frame_i,
  output srbm_pkg::frame_t     scaled_o
);

  localparam int AddrW = $clog2(FRAME_DEPTH);
  localparam logic [AddrW-1:0] LastPos = AddrW'(FRAME_DEPTH - 1);

  logic [31:0]          wr_cnt_q, wr_cnt_d;
  logic [31:0]          rd_cnt_q, rd_cnt_d;
  logic [AddrW-1:0]     wr_pos_q, wr_pos_d;
  logic [AddrW-1:0]     rd_pos_q, rd_pos_d;
  logic                 active_q;
  logic                 unread;
  srbm_pkg::gain_pair_t gain_q;
  srbm_pkg::frame_t     scaled_q;
  srbm_pkg::frame_t     rd_frame;
  logic [31:0]          ram_rdata;
  logic signed [32:0]   prod_l;
  logic signed [32:0]   prod_r;

  assign unread = (wr_cnt_q != rd_cnt_q);

  // position tracks count modulo depth, also across the 32-bit wrap
  always_comb begin
    wr_cnt_d = wr_cnt_q;
    wr_pos_d = wr_pos_q;
    rd_cnt_d = rd_cnt_q;
    rd_pos_d = rd_pos_q;
    if (ctrl_i.wr) begin
      wr_cnt_d = wr_cnt_q + 32'd1;
      wr_pos_d = (wr_cnt_q == '1 || wr_pos_q == LastPos) ? '0 : wr_pos_q + AddrW'(1);
    end
    if (ctrl_i.rd && unread) begin
      rd_cnt_d = rd_cnt_q + 32'd1;
      rd_pos_d = (rd_cnt_q == '1 || rd_pos_q == LastPos) ? '0 : rd_pos_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q <= '0;
      rd_cnt_q <= '0;
      wr_pos_q <= '0;
      rd_pos_q <= '0;
      active_q <= 1'b0;
    end else begin
      wr_cnt_q <= wr_cnt_d;
      rd_cnt_q <= rd_cnt_d;
      wr_pos_q <= wr_pos_d;
      rd_pos_q <= rd_pos_d;
      if (ctrl_i.rd) begin
        active_q <= unread && !mute_i;
      end
    end
  end

  srbm_ram #(
    .WIDTH (32),
    .DEPTH (FRAME_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr),
    .waddr_i (wr_pos_q),
    .wdata_i (wr_frame_i),
    .re_i    (ctrl_i.rd),
    .raddr_i (rd_pos_q),
    .rdata_o (ram_rdata)
  );

  assign rd_frame = srbm_pkg::frame_t'(ram_rdata);

  assign prod_l = rd_frame.left * $signed({1'b0, gain_q.left});
  assign prod_r = rd_frame.right * $signed({1'b0, gain_q.right});

  always_ff @(posedge clk_i) begin
    gain_q.left  <= srbm_pkg::lane_gain(master_i.left, src_gain_i.left);
    gain_q.right <= srbm_pkg::lane_gain(master_i.right, src_gain_i.right);
    if (ctrl_i.mul) begin
      if (active_q) begin
        scaled_q.left  <= prod_l[30:15];
        scaled_q.right <= prod_r[30:15];
      end else begin
        scaled_q <= '0;
      end
    end
  end

  assign scaled_o = scaled_q;

endmodule

@@ rtl/srbm_merge.sv @@
// merge stage: sums the lanes, saturates and holds the result transaction
module srbm_merge #(
  parameter int SOURCES = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  srbm_pkg::frame_t [SOURCES-1:0]     lanes_i,
  output logic                               free_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output srbm_pkg::out_item_t                out_data_o
);

  localparam int SumW = 17 + $clog2(SOURCES);
  localparam logic signed [SumW-1:0] SatMax = SumW'(32767);
  localparam logic signed [SumW-1:0] SatMin = SumW'(-32768);

  logic signed [SumW-1:0] sum_l;
  logic signed [SumW-1:0] sum_r;
  logic signed [15:0]     sat_l;
  logic signed [15:0]     sat_r;
  logic                   out_valid_q;
  srbm_pkg::out_item_t    out_data_q;

  always_comb begin
    sum_l = '0;
    sum_r = '0;
    for (int s = 0; s < SOURCES; s++) begin
      sum_l = sum_l + SumW'(lanes_i[s].left);
      sum_r = sum_r + SumW'(lanes_i[s].right);
    end
    priority if (sum_l > SatMax) begin
      sat_l = 16'sh7fff;
    end else if (sum_l < SatMin) begin
      sat_l = 16'sh8000;
    end else begin
      sat_l = sum_l[15:0];
    end
    priority if (sum_r > SatMax) begin
      sat_r = 16'sh7fff;
    end else if (sum_r < SatMin) begin
      sat_r = 16'sh8000;
    end else begin
      sat_r = sum_r[15:0];
    end
  end

  assign free_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_data_q.mixed_left  <= sat_l;
      out_data_q.mixed_right <= sat_r;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ verif/stereo_ring_buffer_mixer_tb.sv @@
// self-checking testbench for the stereo ring buffer mixer
module stereo_ring_buffer_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_DEPTH      = 16384;
  localparam int SOURCES          = 2;
  localparam int RANDOM_PER_PHASE = 445;
  localparam int CYCLE_LIMIT      = 600000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  srbm_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  srbm_pkg::out_item_t out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [4:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycles = 0;
  int unsigned idle_by_phase[4]  = '{0, 66, 0, 12};
  int unsigned stall_by_phase[4] = '{0, 0, 66, 12};

  class mix_predictor;
    srbm_pkg::frame_t    ring[SOURCES][FRAME_DEPTH];
    bit [31:0]           wr_count[SOURCES];
    bit [31:0]           rd_count[SOURCES];
    logic [15:0]         master_l;
    logic [15:0]         master_r;
    logic [15:0]         src_l[SOURCES];
    logic [15:0]         src_r[SOURCES];
    logic [1:0]          mute;
    srbm_pkg::out_item_t expected_mixes[$];
    int                  errors;

    function new();
      master_l = srbm_pkg::MASTER_GAIN_RST;
      master_r = srbm_pkg::MASTER_GAIN_RST;
      for (int s = 0; s < SOURCES; s++) begin
        src_l[s]    = srbm_pkg::SRC_GAIN_RST;
        src_r[s]    = srbm_pkg::SRC_GAIN_RST;
        wr_count[s] = '0;
        rd_count[s] = '0;
      end
      mute   = srbm_pkg::MUTE_RST;
      errors = 0;
    endfunction

    function void set_reg(srbm_pkg::reg_idx_e idx, logic [31:0] data);
      unique case (idx)
        srbm_pkg::REG_MASTER_L: master_l = data[15:0];
        srbm_pkg::REG_MASTER_R: master_r = data[15:0];
        srbm_pkg::REG_SRC0_L:   src_l[0] = data[15:0];
        srbm_pkg::REG_SRC0_R:   src_r[0] = data[15:0];
        srbm_pkg::REG_SRC1_L:   src_l[1] = data[15:0];
        srbm_pkg::REG_SRC1_R:   src_r[1] = data[15:0];
        srbm_pkg::REG_MUTE:     mute     = data[1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_mixes.size();
    endfunction

    // master times source, floored, capped at unity
    function logic [15:0] capped_gain(logic [15:0] m, logic [15:0] s);
      longint unsigned g;
      g = (longint'(m) * longint'(s)) >> 15;
      if (g > longint'(srbm_pkg::GAIN_UNITY)) begin
        return srbm_pkg::GAIN_UNITY;
      end
      return g[15:0];
    endfunction

    // floor toward minus infinity
    function longint scaled(logic signed [15:0] smp, logic [15:0] g);
      longint p;
      p = longint'(smp) * longint'(g);
      return p >>> 15;
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) begin
        return 16'sh7fff;
      end
      if (v < -32768) begin
        return 16'sh8000;
      end
      return 16'(v);
    endfunction

    function void note_transaction(srbm_pkg::in_item_t item);
      longint              sum_l;
      longint              sum_r;
      srbm_pkg::frame_t    fr;
      srbm_pkg::out_item_t res;
      if (item.command == srbm_pkg::CMD_CAPTURE) begin
        ring[item.source_sel][wr_count[item.source_sel] % FRAME_DEPTH] =
          {item.sample_right, item.sample_left};
        wr_count[item.source_sel]++;
        return;
      end
      sum_l = 0;
      sum_r = 0;
      for (int s = 0; s < SOURCES; s++) begin
        if (wr_count[s] == rd_count[s]) continue;
        if (!mute[s]) begin
          fr = ring[s][rd_count[s] % FRAME_DEPTH];
          sum_l += scaled(fr.left, capped_gain(master_l, src_l[s]));
          sum_r += scaled(fr.right, capped_gain(master_r, src_r[s]));
        end
        rd_count[s]++;
      end
      res.mixed_left  = clamp16(sum_l);
      res.mixed_right = clamp16(sum_r);
      expected_mixes.push_back(res);
    endfunction

    function void check_mix(srbm_pkg::out_item_t got);
      srbm_pkg::out_item_t want;
      if (expected_mixes.size() == 0) begin
        $error("mixed frame with none pending: left %0d right %0d",
               got.mixed_left, got.mixed_right);
        errors++;
        return;
      end
      want = expected_mixes.pop_front();
      if (got.mixed_left !== want.mixed_left) begin
        $error("mixed_left: expected %0d, got %0d", want.mixed_left, got.mixed_left);
        errors++;
      end
      if (got.mixed_right !== want.mixed_right) begin
        $error("mixed_right: expected %0d, got %0d", want.mixed_right, got.mixed_right);
        errors++;
      end
    endfunction
  endclass

  mix_predictor mixp = new();

  stereo_ring_buffer_mixer #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .SOURCES    (SOURCES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mixp.check_mix(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(srbm_pkg::in_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    mixp.note_transaction(item);
    @(negedge clk_i);
  endtask

  task automatic capture(logic sel, logic signed [15:0] l, logic signed [15:0] r);
    srbm_pkg::in_item_t item;
    item.command      = srbm_pkg::CMD_CAPTURE;
    item.source_sel   = sel;
    item.sample_left  = l;
    item.sample_right = r;
    send(item);
  endtask

  task automatic mix();
    srbm_pkg::in_item_t item;
    item.command      = srbm_pkg::CMD_MIX;
    item.source_sel   = 1'($urandom_range(0, 1));
    item.sample_left  = 16'($urandom);
    item.sample_right = 16'($urandom);
    send(item);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (mixp.pending() != 0);
  endtask

  task automatic write_reg(srbm_pkg::reg_idx_e idx, logic [31:0] data);
    logic [31:0] want_rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mixp.set_reg(idx, data);
    @(negedge clk_i);
    want_rd = (idx == srbm_pkg::REG_MUTE) ? 32'(data[1:0]) : 32'(data[15:0]);
    if (prdata !== want_rd) begin
      $error("prdata: expected %0d, got %0d", want_rd, prdata);
      mixp.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // only between phases, once the mixer has gone quiet
  task automatic program_regs(logic [15:0] ml, logic [15:0] mr, logic [15:0] s0l,
                              logic [15:0] s0r, logic [15:0] s1l, logic [15:0] s1r,
                              logic [1:0] mute);
    wait_drained();
    repeat (10) @(negedge clk_i);
    write_reg(srbm_pkg::REG_MASTER_L, {16'($urandom), ml});
    write_reg(srbm_pkg::REG_MASTER_R, {16'($urandom), mr});
    write_reg(srbm_pkg::REG_SRC0_L, {16'($urandom), s0l});
    write_reg(srbm_pkg::REG_SRC0_R, {16'($urandom), s0r});
    write_reg(srbm_pkg::REG_SRC1_L, {16'($urandom), s1l});
    write_reg(srbm_pkg::REG_SRC1_R, {16'($urandom), s1r});
    write_reg(srbm_pkg::REG_MUTE, {30'($urandom), mute});
  endtask

  function automatic logic [15:0] pick_gain();
    unique case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return srbm_pkg::GAIN_UNITY;
      2: return 16'hffff;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample();
    unique case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned cap_pct;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset gains: empty rings, single sources, both sources
    mix();
    capture(1'b0, 16'sh7fff, 16'sh8000);
    mix();
    capture(1'b1, 16'sh8000, 16'sh7fff);
    mix();
    capture(1'b0, -16'sd1, 16'sd1);
    capture(1'b1, -16'sd1, -16'sd1);
    mix();
    mix();

    // unity gains: saturation on both lanes
    program_regs(srbm_pkg::GAIN_UNITY, srbm_pkg::GAIN_UNITY, srbm_pkg::GAIN_UNITY,
                 srbm_pkg::GAIN_UNITY, srbm_pkg::GAIN_UNITY, srbm_pkg::GAIN_UNITY,
                 2'b00);
    capture(1'b0, 16'sh7fff, 16'sh8000);
    capture(1'b1, 16'sh7fff, 16'sh8000);
    mix();
    capture(1'b0, 16'sh8000, 16'sh8000);
    capture(1'b1, 16'sh8000, 16'shffff);
    mix();

    // gains above unity, source zero muted
    program_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 2'b01);
    capture(1'b0, 16'sh1234, -16'sh1234);
    capture(1'b1, 16'sh7fff, 16'sh8000);
    mix();

    // zero master on one lane, everything muted
    program_regs(16'h0000, 16'hffff, srbm_pkg::GAIN_UNITY, 16'h0001, 16'h4000, 16'hffff,
                 2'b11);
    capture(1'b0, 16'sh7fff, 16'sh7fff);
    capture(1'b1, 16'sh8000, 16'sh8000);
    mix();
    mix();

    for (int ph = 0; ph < 4; ph++) begin
      program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                   pick_gain(), 2'($urandom));
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      cap_pct   = $urandom_range(40, 70);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 1 && n == RANDOM_PER_PHASE / 2) begin
          wait_drained();
        end
        if ($urandom_range(0, 99) < cap_pct) begin
          capture(1'($urandom_range(0, 1)), pick_sample(), pick_sample());
        end else begin
          mix();
        end
      end
    end

    // backlog on source zero drained under output stalls
    program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                 pick_gain(), 2'b00);
    idle_pct  = 0;
    stall_pct = 0;
    for (int i = 0; i < 9; i++) begin
      capture(1'b0, 16'($urandom), 16'($urandom));
    end
    capture(1'b1, pick_sample(), pick_sample());
    capture(1'b1, pick_sample(), pick_sample());
    stall_pct = 66;
    for (int i = 0; i < 40; i++) begin
      mix();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mixp.errors == 0 && mixp.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/srbm_pkg.sv
rtl/srbm_ram.sv
rtl/srbm_lane.sv
rtl/srbm_merge.sv
rtl/stereo_ring_buffer_mixer.sv
verif/stereo_ring_buffer_mixer_tb.sv
